// File: rtl/core/dtps_pkg.sv
// ----------------------------------------------------------------------------
// dtps_pkg: shared types and constants of the drum trigger sequencer
// Holds the result, pin and voice control types and the register map codes.
// ----------------------------------------------------------------------------
package dtps_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PCM_ADDR_BITS  = 16;

   // Register map.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLOSED_START      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_END          = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_TICKS       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIM_BIT           = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPEN_BIT          = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLOSED_BIT        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWITCH_ACTIVE_LOW = 3'd6;

   localparam logic [7:0]  COUNT_FULL           = 8'hFF;
   localparam logic [7:0]  SWITCHES_RESET       = 8'hFF;
   localparam logic [7:0]  PULSE_TICKS_RESET    = 8'd16;
   localparam logic [2:0]  RIM_BIT_RESET        = 3'd0;
   localparam logic [2:0]  OPEN_BIT_RESET       = 3'd1;
   localparam logic [2:0]  CLOSED_BIT_RESET     = 3'd2;
   localparam logic [15:0] CLOSED_START_RESET   = 16'h8000;
   localparam logic [15:0] WAVE_END_RESET       = 16'hFFFF;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_PCM  = 1'b1;

   typedef struct packed {
      logic latch;
      logic led_mute;
      logic select_open;
      logic led_closed;
      logic led_open;
      logic trig_hat;
      logic led_rim;
      logic trig_rim;
   } pins_type;

   typedef struct packed {
      pins_type                 pins;
      logic                     clock_on;
      logic                     fetch;
      logic [PCM_ADDR_BITS-1:0] address;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic reload;
   } voice_ctl_type;

   typedef struct packed {
      logic trig_off;
      logic led_off;
   } voice_sts_type;

endpackage

// File: rtl/core/dtps_req_if.sv
// ----------------------------------------------------------------------------
// dtps_req_if: input item channel
// Carries one tick or PCM clock event with the sampled switch byte.
// ----------------------------------------------------------------------------
interface dtps_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] switches;

   modport source (output valid, mode, switches, input ready);
   modport sink   (input valid, mode, switches, output ready);
endinterface

// File: rtl/core/dtps_rsp_if.sv
// ----------------------------------------------------------------------------
// dtps_rsp_if: result channel
// Carries the output levels and the PCM fetch request after one item.
// ----------------------------------------------------------------------------
interface dtps_rsp_if;
   logic        valid;
   logic        ready;
   logic        trig_rim;
   logic        led_rim;
   logic        trig_hat;
   logic        led_open_hat;
   logic        led_closed_hat;
   logic        select_open_hat;
   logic        led_mute;
   logic        pcm_clock_on;
   logic        pcm_latch;
   logic        pcm_fetch;
   logic [dtps_pkg::PCM_ADDR_BITS-1:0] pcm_address;

   modport source (output valid, trig_rim, led_rim, trig_hat, led_open_hat, led_closed_hat,
                   select_open_hat, led_mute, pcm_clock_on, pcm_latch, pcm_fetch,
                   pcm_address, input ready);
   modport sink   (input valid, trig_rim, led_rim, trig_hat, led_open_hat, led_closed_hat,
                   select_open_hat, led_mute, pcm_clock_on, pcm_latch, pcm_fetch,
                   pcm_address, output ready);
endinterface

// File: rtl/core/dtps_csr_if.sv
// ----------------------------------------------------------------------------
// dtps_csr_if: configuration write channel
// Carries a register index and the data to write into it.
// ----------------------------------------------------------------------------
interface dtps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dtps_pkg::CSR_INDEX_BITS-1:0] index;
   logic [dtps_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/dtps_voice.sv
// ----------------------------------------------------------------------------
// dtps_voice: trigger countdown of one drum voice
// Counts down from full on each tick and flags pulse end and LED off.
// ----------------------------------------------------------------------------
module dtps_voice (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              pulse_ticks,
   input  dtps_pkg::voice_ctl_type ctl,
   output dtps_pkg::voice_sts_type sts
);
   import dtps_pkg::*;

   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] count_dec;
   logic [7:0] end_at;
   logic       active;

   assign active    = count_ff != 8'd0;
   assign count_dec = count_ff - 8'd1;
   assign end_at    = COUNT_FULL - pulse_ticks;

   // A reload in the same tick wins over the decrement.
   always_comb begin
      count_in = count_ff;
      if (ctl.tick && active) begin
         count_in = count_dec;
      end
      if (ctl.reload) begin
         count_in = COUNT_FULL;
      end
   end

   assign sts.trig_off = ctl.tick && active && (count_dec == end_at);
   assign sts.led_off  = ctl.tick && (count_ff == 8'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/drum_trigger_pcm_sequencer_top.sv
// ----------------------------------------------------------------------------
// drum_trigger_pcm_sequencer_top: drum trigger controller with PCM playback
// A result transaction is offered in the cycle after its input is taken.
// Throughput: one input per cycle unless the two-entry result queue is full;
// the input side keeps going while one finished result waits to be taken.
// Reset is synchronous and active high; it restores every register but the
// queue entries to its default; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module drum_trigger_pcm_sequencer_top #(
   parameter int ADDR_BITS     = 16,
   parameter int SWITCH_PERIOD = 64,
   parameter int BLINK_PERIOD  = 4096
) (
   input logic       clock,
   input logic       reset,
   dtps_req_if.sink  req_chan,
   dtps_rsp_if.source rsp_chan,
   dtps_csr_if.sink  csr_chan
);
   import dtps_pkg::*;

   // Remainder counters track the divider modulo each period.
   localparam int SW_W = (SWITCH_PERIOD > 1) ? $clog2(SWITCH_PERIOD) : 1;
   localparam int BL_W = (BLINK_PERIOD > 1) ? $clog2(BLINK_PERIOD) : 1;
   localparam logic [SW_W:0] SW_LIMIT = (SW_W + 1)'(SWITCH_PERIOD);
   localparam logic [BL_W:0] BL_LIMIT = (BL_W + 1)'(BLINK_PERIOD);

   // Configuration registers.
   logic [ADDR_BITS-1:0] closed_start_ff;
   logic [ADDR_BITS-1:0] wave_end_ff;
   logic [7:0]           pulse_ticks_ff;
   logic [2:0]           rim_bit_ff;
   logic [2:0]           open_bit_ff;
   logic [2:0]           closed_bit_ff;
   logic                 active_low_ff;

   // Sequencer state.
   logic [15:0]          divider_ff,  divider_in;
   logic [SW_W-1:0]      sw_rem_ff,   sw_rem_in;
   logic [BL_W-1:0]      bl_rem_ff,   bl_rem_in;
   logic [7:0]           last_sw_ff,  last_sw_in;
   logic [ADDR_BITS-1:0] play_addr_ff, play_addr_in;
   logic [ADDR_BITS-1:0] play_limit_ff, play_limit_in;
   logic                 phase_ff,    phase_in;
   logic                 running_ff,  running_in;
   pins_type             pins_ff,     pins_in;

   // Result queue.
   rsp_type              queue_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;

   voice_ctl_type        rim_ctl, hat_ctl;
   voice_sts_type        rim_sts, hat_sts;
   rsp_type              result;
   rsp_type              head;

   logic                 accept;
   logic                 pop;
   logic                 is_tick;
   logic                 is_pcm;
   logic                 div_wrap;
   logic [SW_W:0]        sw_rem_inc;
   logic [BL_W:0]        bl_rem_inc;
   logic                 switch_hit;
   logic                 blink_hit;
   logic                 sw_changed;
   logic                 press_rim, press_open, press_closed;

   assign accept  = req_chan.valid && req_chan.ready;
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign is_tick = accept && (req_chan.mode == MODE_TICK);
   assign is_pcm  = accept && (req_chan.mode == MODE_PCM);

   // Divider and the two period tests. When the 16-bit divider wraps to zero
   // both remainders restart, so they always equal the divider modulo period.
   assign divider_in = divider_ff + 16'd1;
   assign div_wrap   = divider_ff == 16'hFFFF;
   assign sw_rem_inc = {1'b0, sw_rem_ff} + {{SW_W{1'b0}}, 1'b1};
   assign bl_rem_inc = {1'b0, bl_rem_ff} + {{BL_W{1'b0}}, 1'b1};
   assign sw_rem_in  = (div_wrap || sw_rem_inc == SW_LIMIT) ? '0 : sw_rem_inc[SW_W-1:0];
   assign bl_rem_in  = (div_wrap || bl_rem_inc == BL_LIMIT) ? '0 : bl_rem_inc[BL_W-1:0];
   assign switch_hit = is_tick && (sw_rem_in == '0);
   assign blink_hit  = is_tick && (bl_rem_in == '0);

   // A switch reads as pressed when its bit differs from the idle polarity.
   assign sw_changed   = req_chan.switches != last_sw_ff;
   assign press_rim    = req_chan.switches[rim_bit_ff] ^ active_low_ff;
   assign press_open   = req_chan.switches[open_bit_ff] ^ active_low_ff;
   assign press_closed = req_chan.switches[closed_bit_ff] ^ active_low_ff;

   assign rim_ctl.tick   = is_tick;
   assign rim_ctl.reload = switch_hit && sw_changed && press_rim;
   assign hat_ctl.tick   = is_tick;
   assign hat_ctl.reload = switch_hit && sw_changed && (press_open || press_closed);

   dtps_voice u_rim (
      .clock       (clock),
      .reset       (reset),
      .pulse_ticks (pulse_ticks_ff),
      .ctl         (rim_ctl),
      .sts         (rim_sts)
   );

   dtps_voice u_hat (
      .clock       (clock),
      .reset       (reset),
      .pulse_ticks (pulse_ticks_ff),
      .ctl         (hat_ctl),
      .sts         (hat_sts)
   );

   // Next-state logic for one transaction. Countdown clears come first, then
   // triggers in the order rim shot, open hi-hat, closed hi-hat, so a closed
   // hi-hat press overrides an open one in the same sample.
   always_comb begin
      pins_in        = pins_ff;
      last_sw_in     = last_sw_ff;
      play_addr_in   = play_addr_ff;
      play_limit_in  = play_limit_ff;
      phase_in       = phase_ff;
      running_in     = running_ff;
      result.fetch   = 1'b0;
      result.address = '0;

      if (rim_sts.trig_off) begin
         pins_in.trig_rim = 1'b0;
      end
      if (rim_sts.led_off) begin
         pins_in.led_rim = 1'b0;
      end
      if (hat_sts.trig_off) begin
         pins_in.trig_hat = 1'b0;
      end
      if (hat_sts.led_off) begin
         pins_in.led_open   = 1'b0;
         pins_in.led_closed = 1'b0;
      end

      if (switch_hit) begin
         last_sw_in = req_chan.switches;
         if (sw_changed) begin
            if (press_rim) begin
               pins_in.trig_rim = 1'b1;
               pins_in.led_rim  = 1'b1;
            end
            if (press_open) begin
               pins_in.led_open    = 1'b1;
               pins_in.select_open = 1'b1;
               pins_in.led_closed  = 1'b0;
               pins_in.trig_hat    = 1'b1;
               play_addr_in        = '0;
               play_limit_in       = closed_start_ff;
               phase_in            = 1'b0;
               running_in          = 1'b1;
            end
            if (press_closed) begin
               pins_in.led_closed  = 1'b1;
               pins_in.led_open    = 1'b0;
               pins_in.select_open = 1'b0;
               pins_in.trig_hat    = 1'b1;
               play_addr_in        = closed_start_ff;
               play_limit_in       = wave_end_ff;
               phase_in            = 1'b0;
               running_in          = 1'b1;
            end
         end
      end

      if (blink_hit) begin
         pins_in.led_mute = ~pins_ff.led_mute;
      end

      // PCM clock event: phase 0 drops the latch and fetches or stops the
      // clock once the range is used up; phase 1 raises the latch.
      if (is_pcm && running_ff) begin
         if (!phase_ff) begin
            pins_in.latch = 1'b0;
            if (play_addr_ff < play_limit_ff) begin
               result.fetch   = 1'b1;
               result.address = PCM_ADDR_BITS'(play_addr_ff);
               play_addr_in   = play_addr_ff + ADDR_BITS'(1);
            end else begin
               running_in = 1'b0;
            end
         end else begin
            pins_in.latch = 1'b1;
         end
         phase_in = ~phase_ff;
      end

      result.pins     = pins_in;
      result.clock_on = running_in;
   end

   // Configuration writes are always accepted; unknown indexes are dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_start_ff <= ADDR_BITS'(CLOSED_START_RESET);
         wave_end_ff     <= ADDR_BITS'(WAVE_END_RESET);
         pulse_ticks_ff  <= PULSE_TICKS_RESET;
         rim_bit_ff      <= RIM_BIT_RESET;
         open_bit_ff     <= OPEN_BIT_RESET;
         closed_bit_ff   <= CLOSED_BIT_RESET;
         active_low_ff   <= 1'b1;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CLOSED_START:      closed_start_ff <= ADDR_BITS'(csr_chan.data);
            CSR_WAVE_END:          wave_end_ff     <= ADDR_BITS'(csr_chan.data);
            CSR_PULSE_TICKS:       pulse_ticks_ff  <= csr_chan.data[7:0];
            CSR_RIM_BIT:           rim_bit_ff      <= csr_chan.data[2:0];
            CSR_OPEN_BIT:          open_bit_ff     <= csr_chan.data[2:0];
            CSR_CLOSED_BIT:        closed_bit_ff   <= csr_chan.data[2:0];
            CSR_SWITCH_ACTIVE_LOW: active_low_ff   <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff    <= 16'd0;
         sw_rem_ff     <= '0;
         bl_rem_ff     <= '0;
         last_sw_ff    <= SWITCHES_RESET;
         play_addr_ff  <= '1;
         play_limit_ff <= '0;
         phase_ff      <= 1'b0;
         running_ff    <= 1'b0;
         pins_ff       <= '0;
      end else if (accept) begin
         if (is_tick) begin
            divider_ff <= divider_in;
            sw_rem_ff  <= sw_rem_in;
            bl_rem_ff  <= bl_rem_in;
         end
         last_sw_ff    <= last_sw_in;
         play_addr_ff  <= play_addr_in;
         play_limit_ff <= play_limit_in;
         phase_ff      <= phase_in;
         running_ff    <= running_in;
         pins_ff       <= pins_in;
      end
   end

   // Two-entry result queue. Input is refused only when both entries hold
   // results that have not been taken yet.
   assign req_chan.ready = count_ff != 2'd2;

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, accept} - {1'b0, pop};
      end
   end

   assign head = queue_ff[rd_ptr_ff];

   assign rsp_chan.valid           = count_ff != 2'd0;
   assign rsp_chan.trig_rim        = head.pins.trig_rim;
   assign rsp_chan.led_rim         = head.pins.led_rim;
   assign rsp_chan.trig_hat        = head.pins.trig_hat;
   assign rsp_chan.led_open_hat    = head.pins.led_open;
   assign rsp_chan.led_closed_hat  = head.pins.led_closed;
   assign rsp_chan.select_open_hat = head.pins.select_open;
   assign rsp_chan.led_mute        = head.pins.led_mute;
   assign rsp_chan.pcm_clock_on    = head.clock_on;
   assign rsp_chan.pcm_latch       = head.pins.latch;
   assign rsp_chan.pcm_fetch       = head.fetch;
   assign rsp_chan.pcm_address     = head.address;

   // The queue never holds more than two results.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   // A result without a fetch always carries a zero address.
   a_no_fetch_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.pcm_fetch) |-> (rsp_chan.pcm_address == '0))
      else $error("address shown without a fetch");

   // A PCM event on a running clock flips the latch phase.
   a_phase_toggle: assert property (@(posedge clock) disable iff (reset)
      (is_pcm && running_ff) |=> (phase_ff != $past(phase_ff)))
      else $error("latch phase did not toggle");

   // A stopped clock is never restarted by a PCM event.
   a_pcm_no_restart: assert property (@(posedge clock) disable iff (reset)
      (is_pcm && !running_ff) |=> !running_ff)
      else $error("PCM event restarted the clock");

endmodule
